// ===== hw/rtl/lbf_pkg.sv =====
// package for the lorentz boost block: item types, widths and shared helpers
// no dependencies
`timescale 1ns / 1ps
package lbf_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 12;
   localparam int PROD_BITS = 2 * WORD_BITS + 2;
   localparam int MSQ_BITS = 2 * WORD_BITS + 4;
   localparam int ROOT_BITS = (MSQ_BITS + 1) / 2;
   localparam int ROOT_STEPS = ROOT_BITS;
   localparam int DEN_BITS = WORD_BITS + 2;
   localparam int NUMX_BITS = WORD_BITS + 2;
   localparam int QTOP_BITS = 2 * WORD_BITS + 4;
   localparam int DIV_STEPS = 2 * WORD_BITS + 4;

   typedef struct packed {
      logic kind;
      logic signed [WORD_BITS-1:0] part_energy;
      logic signed [WORD_BITS-1:0] part_mom_x;
      logic signed [WORD_BITS-1:0] part_mom_y;
      logic signed [WORD_BITS-1:0] part_mom_z;
      logic signed [WORD_BITS-1:0] ref_energy;
      logic signed [WORD_BITS-1:0] ref_mom_x;
      logic signed [WORD_BITS-1:0] ref_mom_y;
      logic signed [WORD_BITS-1:0] ref_mom_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_energy;
      logic signed [WORD_BITS-1:0] out_mom_x;
      logic signed [WORD_BITS-1:0] out_mom_y;
      logic signed [WORD_BITS-1:0] out_mom_z;
      logic bad_frame;
      logic clipped;
   } rsp_type;

   // one restoring division lane: quotient, remainder, divisor, dividend bits left
   typedef struct packed {
      logic [QTOP_BITS-1:0] num;
      logic [QTOP_BITS:0] rem;
      logic [QTOP_BITS-1:0] quo;
      logic [QTOP_BITS:0] den;
   } div_lane_type;

   typedef struct packed {
      logic [MSQ_BITS-1:0] rad;
      logic [ROOT_BITS+1:0] rem;
      logic [ROOT_BITS-1:0] root;
   } sqrt_lane_type;

   function automatic div_lane_type div_step(div_lane_type a);
      div_lane_type r;
      logic [QTOP_BITS:0] t;
      r = a;
      t = {a.rem[QTOP_BITS-1:0], a.num[QTOP_BITS-1]};
      r.num = {a.num[QTOP_BITS-2:0], 1'b0};
      if (t >= a.den) begin
         r.rem = t - a.den;
         r.quo = {a.quo[QTOP_BITS-2:0], 1'b1};
      end else begin
         r.rem = t;
         r.quo = {a.quo[QTOP_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic sqrt_lane_type sqrt_step(sqrt_lane_type a);
      sqrt_lane_type r;
      logic [ROOT_BITS+1:0] t;
      logic [ROOT_BITS+1:0] trial;
      r = a;
      t = {a.rem[ROOT_BITS-1:0], a.rad[MSQ_BITS-1:MSQ_BITS-2]};
      trial = {a.root, 2'b01};
      r.rad = {a.rad[MSQ_BITS-3:0], 2'b00};
      if (t >= trial) begin
         r.rem = t - trial;
         r.root = {a.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         r.rem = t;
         r.root = {a.root[ROOT_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [WORD_BITS:0] sat_word(logic signed [QTOP_BITS+1:0] v);
      logic signed [QTOP_BITS+1:0] hi;
      logic signed [QTOP_BITS+1:0] lo;
      hi = {{(QTOP_BITS+3-WORD_BITS){1'b0}}, {(WORD_BITS-1){1'b1}}};
      lo = ~hi;
      if (v > hi) return {1'b1, hi[WORD_BITS-1:0]};
      if (v < lo) return {1'b1, lo[WORD_BITS-1:0]};
      return {1'b0, v[WORD_BITS-1:0]};
   endfunction
endpackage

// ===== hw/rtl/lbf_div_cell.sv =====
// one cell of the divider and root chains: one restoring step per cycle
// depends on lbf_pkg
`timescale 1ns / 1ps
module lbf_div_cell (
   input  logic clock,
   input  lbf_pkg::div_lane_type div_in,
   input  lbf_pkg::sqrt_lane_type sqrt_in,
   input  logic sqrt_en,
   output lbf_pkg::div_lane_type div_out,
   output lbf_pkg::sqrt_lane_type sqrt_out
);
   import lbf_pkg::*;
   div_lane_type div_ff;
   sqrt_lane_type sqrt_ff;
   always_ff @(posedge clock) begin
      div_ff <= div_step(div_in);
      sqrt_ff <= sqrt_en ? sqrt_step(sqrt_in) : sqrt_in;
   end
   assign div_out = div_ff;
   assign sqrt_out = sqrt_ff;
endmodule

// ===== hw/rtl/lorentz_boost_to_frame.sv =====
// lorentz boost top: pipeline of restoring cells, one item per cycle
// throughput one item per cycle, busy never rises
// synchronous active-high reset clears the valid chain; results cannot be stalled
// depends on lbf_pkg and lbf_div_cell
`timescale 1ns / 1ps
module lorentz_boost_to_frame (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  lbf_pkg::req_type req_item,
   output logic rsp_strobe,
   output lbf_pkg::rsp_type rsp_item
);
   import lbf_pkg::*;
   localparam int LAT = ROOT_STEPS + DIV_STEPS + DIV_STEPS + 6;
   localparam int SW = QTOP_BITS + 2;

   typedef struct packed {
      logic kind;
      logic bad;
      logic signed [WORD_BITS-1:0] pe;
      logic signed [WORD_BITS-1:0] px;
      logic signed [WORD_BITS-1:0] py;
      logic signed [WORD_BITS-1:0] pz;
      logic signed [WORD_BITS-1:0] re;
      logic signed [WORD_BITS-1:0] rx;
      logic signed [WORD_BITS-1:0] ry;
      logic signed [WORD_BITS-1:0] rz;
      logic signed [SW-1:0] dot;
      logic [ROOT_BITS-1:0] m0;
      logic signed [WORD_BITS-1:0] ep;
      logic clip;
      logic eneg;
      logic dneg;
      logic signed [NUMX_BITS-1:0] nsum;
      logic signed [SW-1:0] tx;
      logic signed [SW-1:0] ty;
      logic signed [SW-1:0] tz;
   } ctx_type;

   logic [LAT-1:0] vld_ff;
   ctx_type ctx_ff [LAT];
   ctx_type ctx_in [LAT];

   // stage 0: products
   logic signed [PROD_BITS-1:0] sq_e_ff, sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [PROD_BITS-1:0] d_e_ff, d_x_ff, d_y_ff, d_z_ff;
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
      sq_e_ff <= PROD_BITS'(req_item.ref_energy * req_item.ref_energy);
      sq_x_ff <= PROD_BITS'(req_item.ref_mom_x * req_item.ref_mom_x);
      sq_y_ff <= PROD_BITS'(req_item.ref_mom_y * req_item.ref_mom_y);
      sq_z_ff <= PROD_BITS'(req_item.ref_mom_z * req_item.ref_mom_z);
      d_e_ff <= PROD_BITS'(req_item.part_energy * req_item.ref_energy);
      d_x_ff <= PROD_BITS'(req_item.part_mom_x * req_item.ref_mom_x);
      d_y_ff <= PROD_BITS'(req_item.part_mom_y * req_item.ref_mom_y);
      d_z_ff <= PROD_BITS'(req_item.part_mom_z * req_item.ref_mom_z);
   end
   always_ff @(posedge clock) req_ff <= req_item;
   assign busy = 1'b0;

   // stage 1: mass squared and dot product
   logic signed [MSQ_BITS:0] msq;
   logic signed [SW-1:0] sp;
   always_comb begin
      msq = (MSQ_BITS+1)'(sq_e_ff) - (MSQ_BITS+1)'(sq_x_ff)
          - (MSQ_BITS+1)'(sq_y_ff) - (MSQ_BITS+1)'(sq_z_ff);
      sp = SW'(d_x_ff) + SW'(d_y_ff) + SW'(d_z_ff);
      ctx_in[0] = '0;
      ctx_in[0].kind = req_ff.kind;
      ctx_in[0].bad = (msq <= 0);
      ctx_in[0].pe = req_ff.part_energy;
      ctx_in[0].px = req_ff.part_mom_x;
      ctx_in[0].py = req_ff.part_mom_y;
      ctx_in[0].pz = req_ff.part_mom_z;
      ctx_in[0].re = req_ff.ref_energy;
      ctx_in[0].rx = req_ff.ref_mom_x;
      ctx_in[0].ry = req_ff.ref_mom_y;
      ctx_in[0].rz = req_ff.ref_mom_z;
      ctx_in[0].dot = req_ff.kind ? SW'(d_e_ff) + sp : SW'(d_e_ff) - sp;
   end

   // root chain: stages 1 .. ROOT_STEPS
   sqrt_lane_type sq_l [ROOT_STEPS+1];
   div_lane_type dv_l [ROOT_STEPS+1];
   sqrt_lane_type sq_seed_ff;
   always_ff @(posedge clock) begin
      sq_seed_ff.rad <= (msq > 0) ? msq[MSQ_BITS-1:0] : '0;
      sq_seed_ff.rem <= '0;
      sq_seed_ff.root <= '0;
      ctx_ff[0] <= ctx_in[0];
   end
   assign sq_l[0] = sq_seed_ff;
   assign dv_l[0] = '0;
   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
      lbf_div_cell u_cell (.clock(clock), .div_in(dv_l[g]), .sqrt_in(sq_l[g]),
         .sqrt_en(1'b1), .div_out(dv_l[g+1]), .sqrt_out(sq_l[g+1]));
      always_ff @(posedge clock) ctx_ff[g+1] <= ctx_ff[g];
   end

   // energy division chain
   localparam int E0 = ROOT_STEPS + 1;
   div_lane_type de_l [DIV_STEPS+1];
   sqrt_lane_type ds_l [DIV_STEPS+1];
   logic [QTOP_BITS-1:0] e_mag;
   always_comb begin
      ctx_in[E0] = ctx_ff[E0-1];
      ctx_in[E0].m0 = sq_l[ROOT_STEPS].root;
      ctx_in[E0].eneg = ctx_ff[E0-1].dot < 0;
      e_mag = QTOP_BITS'(ctx_in[E0].eneg ? -ctx_ff[E0-1].dot : ctx_ff[E0-1].dot);
   end
   div_lane_type de_seed_ff;
   always_ff @(posedge clock) begin
      ctx_ff[E0] <= ctx_in[E0];
      de_seed_ff.num <= QTOP_BITS'({e_mag, 1'b0} + QTOP_BITS'(sq_l[ROOT_STEPS].root));
      de_seed_ff.rem <= '0;
      de_seed_ff.quo <= '0;
      de_seed_ff.den <= (QTOP_BITS+1)'({sq_l[ROOT_STEPS].root, 1'b0});
   end
   assign de_l[0] = de_seed_ff;
   assign ds_l[0] = '0;
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_ediv
      lbf_div_cell u_cell (.clock(clock), .div_in(de_l[g]), .sqrt_in(ds_l[g]),
         .sqrt_en(1'b0), .div_out(de_l[g+1]), .sqrt_out(ds_l[g+1]));
      always_ff @(posedge clock) ctx_ff[E0+g+1] <= ctx_ff[E0+g];
   end

   // saturate e', build numerator sum and momentum products
   localparam int E1 = E0 + DIV_STEPS + 1;
   logic [WORD_BITS:0] esat;
   logic signed [SW-1:0] eq;
   always_comb begin
      eq = ctx_ff[E1-1].eneg ? -SW'(de_l[DIV_STEPS].quo) : SW'(de_l[DIV_STEPS].quo);
      esat = sat_word(eq);
      ctx_in[E1] = ctx_ff[E1-1];
      ctx_in[E1].ep = esat[WORD_BITS-1:0];
      ctx_in[E1].clip = esat[WORD_BITS];
      ctx_in[E1].nsum = NUMX_BITS'(ctx_ff[E1-1].pe) + NUMX_BITS'(ctx_in[E1].ep);
   end
   always_ff @(posedge clock) ctx_ff[E1] <= ctx_in[E1];

   localparam int E2 = E1 + 1;
   always_comb begin
      ctx_in[E2] = ctx_ff[E2-1];
      ctx_in[E2].tx = SW'(ctx_ff[E2-1].nsum * ctx_ff[E2-1].rx);
      ctx_in[E2].ty = SW'(ctx_ff[E2-1].nsum * ctx_ff[E2-1].ry);
      ctx_in[E2].tz = SW'(ctx_ff[E2-1].nsum * ctx_ff[E2-1].rz);
   end
   always_ff @(posedge clock) ctx_ff[E2] <= ctx_in[E2];

   // momentum division chains, three lanes
   localparam int E3 = E2 + 1;
   logic signed [DEN_BITS-1:0] den;
   logic [DEN_BITS-1:0] den_mag;
   logic [QTOP_BITS-1:0] tm [3];
   logic tn [3];
   always_comb begin
      den = DEN_BITS'(ctx_ff[E3-1].m0) + DEN_BITS'(ctx_ff[E3-1].re);
      den_mag = den < 0 ? DEN_BITS'(-den) : DEN_BITS'(den);
      tn[0] = ctx_ff[E3-1].tx < 0;
      tn[1] = ctx_ff[E3-1].ty < 0;
      tn[2] = ctx_ff[E3-1].tz < 0;
      tm[0] = QTOP_BITS'(tn[0] ? -ctx_ff[E3-1].tx : ctx_ff[E3-1].tx);
      tm[1] = QTOP_BITS'(tn[1] ? -ctx_ff[E3-1].ty : ctx_ff[E3-1].ty);
      tm[2] = QTOP_BITS'(tn[2] ? -ctx_ff[E3-1].tz : ctx_ff[E3-1].tz);
      ctx_in[E3] = ctx_ff[E3-1];
      ctx_in[E3].dneg = den < 0;
      ctx_in[E3].tx = tn[0] ? SW'(-1) : SW'(0);
      ctx_in[E3].ty = tn[1] ? SW'(-1) : SW'(0);
      ctx_in[E3].tz = (den == 0) ? SW'(1) : (tn[2] ? SW'(-1) : SW'(0));
   end
   always_ff @(posedge clock) ctx_ff[E3] <= ctx_in[E3];

   div_lane_type dm_l [3][DIV_STEPS+1];
   sqrt_lane_type dms_l [3][DIV_STEPS+1];
   for (genvar k = 0; k < 3; k++) begin : g_lane
      div_lane_type seed_ff;
      always_ff @(posedge clock) begin
         seed_ff.num <= QTOP_BITS'({tm[k], 1'b0} + QTOP_BITS'(den_mag));
         seed_ff.rem <= '0;
         seed_ff.quo <= '0;
         seed_ff.den <= (QTOP_BITS+1)'({den_mag, 1'b0});
      end
      assign dm_l[k][0] = seed_ff;
      assign dms_l[k][0] = '0;
      for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
         lbf_div_cell u_cell (.clock(clock), .div_in(dm_l[k][g]),
            .sqrt_in(dms_l[k][g]), .sqrt_en(1'b0), .div_out(dm_l[k][g+1]),
            .sqrt_out(dms_l[k][g+1]));
      end
   end
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_mctx
      always_ff @(posedge clock) ctx_ff[E3+g+1] <= ctx_ff[E3+g];
   end

   // final sums and saturation
   localparam int EL = E3 + DIV_STEPS;
   logic signed [SW-1:0] dl [3];
   logic signed [SW-1:0] rs [3];
   logic [WORD_BITS:0] so [3];
   logic neg_d [3];
   logic zero_den;
   rsp_type rsp_in, rsp_ff;
   logic strobe_ff;
   always_comb begin
      zero_den = ctx_ff[EL].tz == SW'(1);
      neg_d[0] = ctx_ff[EL].tx[0] ^ ctx_ff[EL].dneg ^ !ctx_ff[EL].kind;
      neg_d[1] = ctx_ff[EL].ty[0] ^ ctx_ff[EL].dneg ^ !ctx_ff[EL].kind;
      neg_d[2] = ctx_ff[EL].tz[0] ^ ctx_ff[EL].dneg ^ !ctx_ff[EL].kind;
      for (int k = 0; k < 3; k++) begin
         dl[k] = neg_d[k] ? -SW'(dm_l[k][DIV_STEPS].quo) : SW'(dm_l[k][DIV_STEPS].quo);
         if (zero_den) dl[k] = '0;
      end
      rs[0] = SW'(ctx_ff[EL].px) + dl[0];
      rs[1] = SW'(ctx_ff[EL].py) + dl[1];
      rs[2] = SW'(ctx_ff[EL].pz) + dl[2];
      for (int k = 0; k < 3; k++) so[k] = sat_word(rs[k]);
      rsp_in.out_energy = ctx_ff[EL].ep;
      rsp_in.out_mom_x = so[0][WORD_BITS-1:0];
      rsp_in.out_mom_y = so[1][WORD_BITS-1:0];
      rsp_in.out_mom_z = so[2][WORD_BITS-1:0];
      rsp_in.bad_frame = ctx_ff[EL].bad;
      rsp_in.clipped = ctx_ff[EL].clip | so[0][WORD_BITS] | so[1][WORD_BITS]
                     | so[2][WORD_BITS];
      if (ctx_ff[EL].bad) begin
         rsp_in = '0;
         rsp_in.bad_frame = 1'b1;
      end
   end
   for (genvar g = EL + 1; g < LAT; g++) begin : g_pad
      always_comb ctx_in[g] = ctx_ff[g-1];
      always_ff @(posedge clock) ctx_ff[g] <= ctx_in[g];
   end
   for (genvar g = 1; g < E0; g++) begin : g_fill_a
      assign ctx_in[g] = ctx_ff[g-1];
   end
   for (genvar g = E0 + 1; g < E1; g++) begin : g_fill_b
      assign ctx_in[g] = ctx_ff[g-1];
   end
   for (genvar g = E3 + 1; g <= EL; g++) begin : g_fill_c
      assign ctx_in[g] = ctx_ff[g-1];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[EL+1];
      end
      rsp_ff <= rsp_in;
   end
   assign rsp_strobe = strobe_ff;
   assign rsp_item = rsp_ff;
endmodule
